>>> sv/upe_pkg.sv
package upe_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int CIDX_W = 3;
    localparam int PADDR_W = 3;

    localparam logic [0:0] REG_COMPAT_MODE = 1'b0;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_HEX,
        KIND_WIDE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       fin;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    localparam logic [7:0] CH_PCT = 8'h25;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    function automatic logic [7:0] wide_char(input logic [CIDX_W-1:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = CH_PCT;
            3'd1:    c = 8'h43;
            3'd2:    c = 8'h33;
            3'd3:    c = CH_PCT;
            3'd4:    c = 8'h42;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

    function automatic logic [CIDX_W-1:0] last_index(input kind_t kind);
        logic [CIDX_W-1:0] n;
        unique case (kind)
            KIND_PASS: n = 3'd0;
            KIND_HEX:  n = 3'd2;
            KIND_WIDE: n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] char_at(input desc_t d, input logic [CIDX_W-1:0] k);
        logic [7:0] c;
        unique case (d.kind)
            KIND_PASS: c = d.data;
            KIND_HEX:
            begin
                if (k == 3'd0)
                begin
                    c = CH_PCT;
                end
                else if (k == 3'd1)
                begin
                    c = hex_char(d.data[7:4]);
                end
                else
                begin
                    c = hex_char(d.data[3:0]);
                end
            end
            KIND_WIDE: c = wide_char(k);
            default:   c = d.data;
        endcase
        return c;
    endfunction

endpackage

>>> sv/upe_front.sv
module upe_front
    import upe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       compat_mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    input  qstat_t     qstat,
    output logic       push,
    output desc_t      push_desc
);

    logic  valid_reg;
    logic  valid_next;
    desc_t desc_reg;
    desc_t desc_next;
    logic  in_table;
    logic  unreserved;
    logic  escape;
    logic  accept;

    always_comb
    begin
        case (in_byte) inside
            8'h22, 8'h23, 8'h5C, 8'h2A, 8'h2F,
            8'h3A, 8'h3D, 8'h3F, 8'hFF, 8'h25: in_table = 1'b1;
            default:                           in_table = 1'b0;
        endcase
        unreserved = (in_byte >= 8'h30 && in_byte <= 8'h39) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h5A) ||
                     (in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                     in_byte == 8'h2D || in_byte == 8'h5F ||
                     in_byte == 8'h2E || in_byte == 8'h7E;
        escape = compat_mode ? in_table : !unreserved;
    end

    assign push     = valid_reg && !qstat.full;
    assign in_ready = !valid_reg || !qstat.full;
    assign accept   = in_valid && in_ready;
    assign push_desc = desc_reg;

    always_comb
    begin
        desc_next = desc_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            desc_next.data = in_byte;
            desc_next.fin = final_byte;
            if (!escape)
            begin
                desc_next.kind = KIND_PASS;
            end
            else if (in_byte == 8'hFF)
            begin
                desc_next.kind = KIND_WIDE;
            end
            else
            begin
                desc_next.kind = KIND_HEX;
            end
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

>>> sv/upe_queue.sv
module upe_queue
    import upe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  desc_t  push_desc,
    input  logic   pop,
    output desc_t  head,
    output qstat_t qstat
);

    desc_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == QDEPTH[QPTR_W:0]);
    assign qstat.empty = (count_reg == '0);
    assign do_push = push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> sv/upe_back.sv
module upe_back
    import upe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  desc_t      head,
    input  qstat_t     qstat,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       string_end
);

    logic              valid_reg;
    logic              valid_next;
    logic [7:0]        char_reg;
    logic [7:0]        char_next;
    logic              last_reg;
    logic              last_next;
    logic              end_reg;
    logic              end_next;
    logic [CIDX_W-1:0] idx_reg;
    logic [CIDX_W-1:0] idx_next;
    logic              load;
    logic              is_last;

    assign load    = !valid_reg || out_ready;
    assign is_last = (idx_reg == last_index(head.kind));
    assign pop     = load && !qstat.empty && is_last;

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = !qstat.empty;
            char_next  = char_at(head, idx_reg);
            last_next  = is_last;
            end_next   = is_last && head.fin;
            if (!qstat.empty)
            begin
                idx_next = is_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    assign out_valid  = valid_reg;
    assign out_char   = char_reg;
    assign run_last   = last_reg;
    assign string_end = end_reg;

endmodule

>>> sv/url_percent_encoder.sv
// URL percent encoder.
// Input channel: one string byte per beat (in_byte, final_byte) on in_valid/in_ready.
// Output channel: one encoded character per beat (out_char, run_last, string_end)
// on out_valid/out_ready. run_last marks the last character of a byte's run;
// string_end marks the last character of the final byte's run.
// A byte yields 1 character (passed through), 3 (%XX) or 6 (0xFF as %C3%BF).
// compat_mode (APB, address 0, bit 0) selects escaping of table bytes only.
// The first character of a byte passes through the front stage register, a queue
// entry and the output register.
// Throughput: one output character per cycle, set by the output sequencer, while
// out_ready is high and the queue holds a byte. The front stage and a
// 4-entry queue keep accepting bytes while the back end emits.
// Reset clears compat_mode, the queue and both valid stages.
// When out_ready is low the output beat holds; the queue fills and then
// in_ready drops until room frees up.
module url_percent_encoder
    import upe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               final_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               run_last,
    output logic               string_end
);

    logic   compat_mode_reg;
    logic   compat_mode_next;
    qstat_t qstat;
    logic   push;
    desc_t  push_desc;
    logic   pop;
    desc_t  head;

    assign pready = 1'b1;

    always_comb
    begin
        compat_mode_next = compat_mode_reg;
        if (psel && penable && pwrite && paddr[PADDR_W-1 -: 1] == REG_COMPAT_MODE)
        begin
            compat_mode_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1 -: 1] == REG_COMPAT_MODE)
        begin
            prdata = {31'd0, compat_mode_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compat_mode_reg <= 1'b0;
        end
        else
        begin
            compat_mode_reg <= compat_mode_next;
        end
    end

    upe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .compat_mode (compat_mode_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .final_byte  (final_byte),
        .qstat       (qstat),
        .push        (push),
        .push_desc   (push_desc)
    );

    upe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    upe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule
